>>> rtl/core/elru_pkg.sv
// Shared types and constants for the exact LRU frame replacement block.
`timescale 1ns / 1ps
package elru_pkg;

  localparam int FRAME_W    = 6;             // width of a frame number on the ports
  localparam int FRAME_SPAN = 1 << FRAME_W;  // frame numbers the ports can carry
  localparam int CMP_W      = FRAME_W + 1;   // wide enough to hold FRAME_SPAN
  localparam int S_TDATA_W  = 8;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 8;
  localparam int M_PAD_W    = M_TDATA_W - FRAME_W - 1;

  // Event kinds carried in tuser
  localparam logic FUNC_REF   = 1'b0;
  localparam logic FUNC_EVICT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_APPEND,
    ST_EVICT
  } lru_state_e;

endpackage

>>> rtl/core/exact_lru_frame_replacement_top.sv
// Exact LRU replacement over physical frames, kept as a doubly linked list in pointer memories.
// An evict result is registered and offered in the cycle after its transaction is taken.
// A reference to an absent, out-of-range or most recent frame ends in ST_IDLE, one to a present frame
//   passes ST_UNLINK and ST_APPEND, an evict on a non-empty order ST_EVICT; input waits for ST_IDLE.
//   The registered successor read and one write port per pointer memory (next, prev) set these steps.
// Reset: present bits, list head/tail, entry count and output valid clear at once; the pointer
//   memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module exact_lru_frame_replacement_top
  import elru_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [5:0] frame_index, [7:6] zero
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [5:0] evicted_frame, [6] empty_error, [7] zero
);

  // Only frame numbers the port can carry ever enter the list
  localparam int NFR = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
  localparam int PW  = $clog2(NFR);
  localparam int CW  = $clog2(NFR + 1);

  lru_state_e state_q, state_d;

  logic [PW-1:0]  head_q, head_d;
  logic [PW-1:0]  tail_q, tail_d;
  logic [CW-1:0]  count_q, count_d;
  logic [NFR-1:0] present_q, present_d;
  logic [PW-1:0]  frame_q, frame_d;

  logic [PW-1:0] next_mem [NFR];
  logic [PW-1:0] prev_mem [NFR];
  logic [PW-1:0] rd_next_q, rd_prev_q;

  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          nxt_we, prv_we;
  logic [PW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  logic               out_valid_q;
  logic [FRAME_W-1:0] out_victim_q, out_victim_d;
  logic               out_err_q, out_err_d;
  logic               load_out;

  logic          in_acc;
  logic          in_range;
  logic [PW-1:0] in_frame;
  logic          out_busy;

  assign in_frame = s_axis_tdata[PW-1:0];
  assign in_range = (CMP_W'(s_axis_tdata[FRAME_W-1:0]) < CMP_W'(NFR));
  assign out_busy = out_valid_q && !m_axis_tready;

  // Take input only in ST_IDLE, and hold off an evict while the result register is still occupied
  assign s_axis_tready = (state_q == ST_IDLE) && !(s_axis_tuser[0] == FUNC_EVICT && out_busy);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    present_d    = present_q;
    frame_d      = frame_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    nxt_we       = 1'b0;
    nxt_wa       = tail_q;
    nxt_wd       = frame_q;
    prv_we       = 1'b0;
    prv_wa       = frame_q;
    prv_wd       = tail_q;
    load_out     = 1'b0;
    out_victim_d = '0;
    out_err_d    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0] == FUNC_EVICT) begin
            load_out = 1'b1;
            if (count_q == '0) begin
              out_err_d = 1'b1;
            end else begin
              out_victim_d      = FRAME_W'(head_q);
              present_d[head_q] = 1'b0;
              count_d           = count_q - CW'(1);
              rd_en             = 1'b1;
              rd_addr           = head_q;
              state_d           = ST_EVICT;
            end
          end else if (in_range) begin
            if (!present_q[in_frame]) begin
              // Append a new frame at the most recent end
              if (count_q != '0) begin
                nxt_we = 1'b1;
                nxt_wa = tail_q;
                nxt_wd = in_frame;
              end else begin
                head_d = in_frame;
              end
              prv_we              = 1'b1;
              prv_wa              = in_frame;
              prv_wd              = tail_q;
              tail_d              = in_frame;
              present_d[in_frame] = 1'b1;
              count_d             = count_q + CW'(1);
            end else if (tail_q != in_frame) begin
              rd_en   = 1'b1;
              rd_addr = in_frame;
              frame_d = in_frame;
              state_d = ST_UNLINK;
            end
          end
        end
      end
      ST_UNLINK: begin
        // Close the gap: successor points back to predecessor and, unless the frame is the head, vice versa
        prv_we = 1'b1;
        prv_wa = rd_next_q;
        prv_wd = rd_prev_q;
        if (frame_q == head_q) begin
          head_d = rd_next_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = rd_prev_q;
          nxt_wd = rd_next_q;
        end
        state_d = ST_APPEND;
      end
      ST_APPEND: begin
        nxt_we  = 1'b1;
        nxt_wa  = tail_q;
        nxt_wd  = frame_q;
        prv_we  = 1'b1;
        prv_wa  = frame_q;
        prv_wd  = tail_q;
        tail_d  = frame_q;
        state_d = ST_IDLE;
      end
      ST_EVICT: begin
        // Advance the head to the old head's successor
        head_d  = rd_next_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      present_q <= present_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (load_out) begin
      out_victim_q <= out_victim_d;
      out_err_q    <= out_err_d;
    end
  end

  // Pointer memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (rd_en) begin
      rd_next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      rd_prev_q <= prev_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_err_q, out_victim_q};

endmodule

>>> rtl/core/elru_checker.sv
// Port-level checks for the exact LRU frame replacement block, bound to the top level.
`timescale 1ns / 1ps
module elru_checker
  import elru_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every evict transaction yields a result in the next cycle
  a_evict_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser[0] == FUNC_EVICT |=> m_axis_tvalid)
    else $error("evict gave no result");

  // A reference never yields a result
  a_ref_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser[0] == FUNC_REF && (!m_axis_tvalid || m_axis_tready)
    |=> !m_axis_tvalid)
    else $error("reference produced a result");

  // An evict is taken only when the result register can take it
  a_evict_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && s_axis_tuser[0] == FUNC_EVICT |-> !m_axis_tvalid || m_axis_tready)
    else $error("evict taken while result stalled");

  // An empty-order error carries frame zero
  a_err_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FRAME_W] |-> m_axis_tdata[FRAME_W-1:0] == '0)
    else $error("error result with non-zero frame");

  logic unused_tdata;
  assign unused_tdata = ^s_axis_tdata;

endmodule

bind exact_lru_frame_replacement_top elru_checker u_elru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
